### hdl/drrip_pkg.sv
// Package with shared types, codes and default sizes for the DRRIP replacement engine.
package drrip_pkg;

   localparam int DEF_NUM_SETS    = 2048;
   localparam int DEF_NUM_WAYS    = 16;
   localparam int DEF_VALUE_BITS  = 2;
   localparam int DEF_DUEL_BITS   = 10;
   localparam int DEF_NUM_LEADERS = 32;

   localparam int FUNC_W    = 1;
   localparam int SET_IDX_W = 11;
   localparam int WAY_IDX_W = 4;
   localparam int VICTIM_W  = 4;

   // Leader set formulas: static leaders at MUL_A*i, bimodal at MUL_B*i + OFS_B.
   localparam int LEAD_MUL_A = 37;
   localparam int LEAD_MUL_B = 71;
   localparam int LEAD_OFS_B = 13;

   localparam logic [FUNC_W-1:0] FUNC_VICTIM = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 1'b1;

   typedef enum logic [1:0] {
      ROLE_FOLLOW  = 2'd0,
      ROLE_STATIC  = 2'd1,
      ROLE_BIMODAL = 2'd2
   } role_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_LEAD,
      ST_IDLE,
      ST_REDUCE,
      ST_READ,
      ST_AGE
   } state_type;

endpackage

### hdl/drrip_cache_replacement.sv
// DRRIP replacement engine: per-set re-reference values, set dueling and victim selection.
// One request is worked on at a time. A request first subtracts NUM_SETS from set_index
// as often as needed (never by default), then reads its row; an update writes the row back,
// a victim request ages the row by one step per cycle until a way is at the maximum and then
// waits until the previous response is taken. After reset, the rows are cleared and then
// the leader roles are written, with req_ready low.
module drrip_cache_replacement #(
   parameter int NUM_SETS    = drrip_pkg::DEF_NUM_SETS,
   parameter int NUM_WAYS    = drrip_pkg::DEF_NUM_WAYS,
   parameter int VALUE_BITS  = drrip_pkg::DEF_VALUE_BITS,
   parameter int DUEL_BITS   = drrip_pkg::DEF_DUEL_BITS,
   parameter int NUM_LEADERS = drrip_pkg::DEF_NUM_LEADERS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [drrip_pkg::FUNC_W-1:0]       req_func,
   input  logic [drrip_pkg::SET_IDX_W-1:0]    req_set_index,
   input  logic [drrip_pkg::WAY_IDX_W-1:0]    req_way_index,
   input  logic                               req_was_hit,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [drrip_pkg::VICTIM_W-1:0]     rsp_victim_way
);
   import drrip_pkg::*;

   localparam int SET_W  = $clog2(NUM_SETS);
   localparam int WAY_W  = $clog2(NUM_WAYS);
   localparam int LEAD_W = (NUM_LEADERS > 1) ? $clog2(NUM_LEADERS) : 1;

   localparam logic [VALUE_BITS-1:0] VAL_MAX = {VALUE_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0] VAL_BIM = VALUE_BITS'(((1 << VALUE_BITS) - 1) - 1);
   localparam logic [DUEL_BITS-1:0]  DUEL_MAX = {DUEL_BITS{1'b1}};
   localparam logic [DUEL_BITS-1:0]  DUEL_MID = DUEL_BITS'(((1 << DUEL_BITS) - 1) / 2);

   localparam int STEP_A = LEAD_MUL_A % NUM_SETS;
   localparam int STEP_B = LEAD_MUL_B % NUM_SETS;
   localparam int A_LAST = (LEAD_MUL_A * (NUM_LEADERS - 1)) % NUM_SETS;
   localparam int B_LAST = (LEAD_MUL_B * (NUM_LEADERS - 1) + LEAD_OFS_B) % NUM_SETS;

   typedef logic [NUM_WAYS-1:0][VALUE_BITS-1:0] row_type;

   // Storage
   row_type  rrpv_mem_ff [NUM_SETS];
   role_type role_mem_ff [NUM_SETS];
   row_type  row_rd_ff;
   role_type role_rd_ff;

   // Control state
   state_type              state_ff, state_in;
   logic [SET_W-1:0]       clr_ff, clr_in;
   logic [LEAD_W-1:0]      lead_i_ff, lead_i_in;
   logic                   lead_b_ff, lead_b_in;
   logic [SET_W-1:0]       lead_a_ff, lead_a_in;
   logic [SET_W-1:0]       lead_bs_ff, lead_bs_in;
   logic [DUEL_BITS-1:0]   duel_ff, duel_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload
   logic [VICTIM_W-1:0]    rsp_way_ff, rsp_way_in;
   logic [FUNC_W-1:0]      func_ff, func_in;
   logic [SET_IDX_W-1:0]   red_ff, red_in;
   logic [WAY_IDX_W-1:0]   way_ff, way_in;
   logic                   hit_ff, hit_in;
   row_type                work_ff, work_in;

   // Memory controls
   logic                   rd_en;
   logic [SET_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [SET_W-1:0]       wr_addr;
   row_type                wr_data;
   logic                   role_wr_en;
   logic [SET_W-1:0]       role_wr_addr;
   role_type               role_wr_data;

   // Row unit results
   logic                   found;
   logic [WAY_W-1:0]       victim;
   row_type                aged;
   row_type                updated;
   logic [VALUE_BITS-1:0]  ins_val;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;

   // Row unit: find the first way at the maximum and age every way by one.
   always_comb begin
      found  = 1'b0;
      victim = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (work_ff[w] == VAL_MAX) begin
            found  = 1'b1;
            victim = WAY_W'(w);
         end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged[w] = work_ff[w] + VALUE_BITS'(1);
      end
   end

   // Insertion value for an update and the row with that way replaced.
   always_comb begin
      if (hit_ff) begin
         ins_val = '0;
      end else begin
         case (role_rd_ff)
            ROLE_STATIC:  ins_val = '0;
            ROLE_BIMODAL: ins_val = VAL_BIM;
            default:      ins_val = (duel_ff >= DUEL_MID) ? VAL_BIM : '0;
         endcase
      end
      updated = row_rd_ff;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (int'(way_ff) == w) begin
            updated[w] = ins_val;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      lead_i_in    = lead_i_ff;
      lead_b_in    = lead_b_ff;
      lead_a_in    = lead_a_ff;
      lead_bs_in   = lead_bs_ff;
      duel_in      = duel_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_way_in   = rsp_way_ff;
      func_in      = func_ff;
      red_in       = red_ff;
      way_in       = way_ff;
      hit_in       = hit_ff;
      work_in      = work_ff;
      rd_en        = 1'b0;
      rd_addr      = SET_W'(red_ff);
      wr_en        = 1'b0;
      wr_addr      = SET_W'(red_ff);
      wr_data      = work_ff;
      role_wr_en   = 1'b0;
      role_wr_addr = clr_ff;
      role_wr_data = ROLE_FOLLOW;

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_ff;
            wr_data    = {NUM_WAYS{VAL_MAX}};
            role_wr_en = 1'b1;
            if (clr_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_LEAD;
            end else begin
               clr_in = clr_ff + SET_W'(1);
            end
         end
         // Leaders are written last index first, bimodal before static, so that
         // the earliest claim in formula order is the one that stays.
         ST_LEAD: begin
            role_wr_en = 1'b1;
            if (lead_b_ff) begin
               role_wr_addr = lead_bs_ff;
               role_wr_data = ROLE_BIMODAL;
               lead_b_in    = 1'b0;
            end else begin
               role_wr_addr = lead_a_ff;
               role_wr_data = ROLE_STATIC;
               lead_b_in    = 1'b1;
               lead_i_in    = lead_i_ff - LEAD_W'(1);
               if (lead_a_ff >= SET_W'(STEP_A)) begin
                  lead_a_in = lead_a_ff - SET_W'(STEP_A);
               end else begin
                  lead_a_in = lead_a_ff + SET_W'(NUM_SETS - STEP_A);
               end
               if (lead_bs_ff >= SET_W'(STEP_B)) begin
                  lead_bs_in = lead_bs_ff - SET_W'(STEP_B);
               end else begin
                  lead_bs_in = lead_bs_ff + SET_W'(NUM_SETS - STEP_B);
               end
               if (lead_i_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               red_in   = req_set_index;
               way_in   = req_way_index;
               hit_in   = req_was_hit;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (int'(red_ff) >= NUM_SETS) begin
               red_in = red_ff - SET_IDX_W'(NUM_SETS);
            end else begin
               rd_en    = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            case (func_ff)
               FUNC_VICTIM: begin
                  work_in  = row_rd_ff;
                  state_in = ST_AGE;
               end
               default: begin
                  state_in = ST_IDLE;
                  if (int'(way_ff) < NUM_WAYS) begin
                     wr_en   = 1'b1;
                     wr_data = updated;
                     if (!hit_ff) begin
                        case (role_rd_ff)
                           ROLE_STATIC: begin
                              if (duel_ff != DUEL_MAX) duel_in = duel_ff + DUEL_BITS'(1);
                           end
                           ROLE_BIMODAL: begin
                              if (duel_ff != '0) duel_in = duel_ff - DUEL_BITS'(1);
                           end
                           default: duel_in = duel_ff;
                        endcase
                     end
                  end
               end
            endcase
         end
         ST_AGE: begin
            if (!found) begin
               work_in = aged;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // The aged row is written back as the result is handed over.
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_way_in   = VICTIM_W'(victim);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         lead_i_ff    <= LEAD_W'(NUM_LEADERS - 1);
         lead_b_ff    <= 1'b1;
         lead_a_ff    <= SET_W'(A_LAST);
         lead_bs_ff   <= SET_W'(B_LAST);
         duel_ff      <= DUEL_MID;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         lead_i_ff    <= lead_i_in;
         lead_b_ff    <= lead_b_in;
         lead_a_ff    <= lead_a_in;
         lead_bs_ff   <= lead_bs_in;
         duel_ff      <= duel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_way_ff <= rsp_way_in;
      func_ff    <= func_in;
      red_ff     <= red_in;
      way_ff     <= way_in;
      hit_ff     <= hit_in;
      work_ff    <= work_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rrpv_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         row_rd_ff <= rrpv_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (role_wr_en) begin
         role_mem_ff[role_wr_addr] <= role_wr_data;
      end
      if (rd_en) begin
         role_rd_ff <= role_mem_ff[rd_addr];
      end
   end

endmodule
